// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCAM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/scam_pkg.sv
// types and constants of the sector chain allocation map
`default_nettype none

package scam_pkg;

  localparam logic [2:0] CMD_FORMAT      = 3'd0;
  localparam logic [2:0] CMD_ALLOC_FIRST = 3'd1;
  localparam logic [2:0] CMD_ALLOC_NEXT  = 3'd2;
  localparam logic [2:0] CMD_FREE_CHAIN  = 3'd3;
  localparam logic [2:0] CMD_LOOKUP      = 3'd4;
  localparam logic [2:0] CMD_COUNT_FREE  = 3'd5;

  localparam logic       STATUS_OK       = 1'b0;
  localparam logic       STATUS_NO_SPACE = 1'b1;

  localparam logic [15:0] FREE_MARK = 16'hffff;
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  tail_sector;
    logic [9:0]  chain_start;
    logic [10:0] chain_length;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] sector;
    logic [10:0] free_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FORMAT,
    ST_SCAN,
    ST_LINK_TAIL,
    ST_LINK_SELF,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LOOKUP_RD,
    ST_LOOKUP_WAIT,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/scam_map_ram.sv
// sector map storage: one write port, one read port with registered data
`default_nettype none

module scam_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sector_chain_allocation_map.sv
// top level of the sector chain allocation map
// The map holds one 16-bit next pointer per sector in a single-port-write,
// single-port-read memory, and every command is carried out by one sequencer
// that touches at most one map entry per cycle. After reset a clearing pass
// writes every entry free, during which no command is accepted (the register
// port is open throughout). Format writes every entry, count free reads every
// entry, allocate first or next scan for a free entry and, on finding one,
// make one or two link writes (allocate next with no free sector goes on to
// walk the given chain), free chain reads and then frees each link in turn,
// and lookup reads one entry; each result then passes through the response
// state into the output register. A new command is taken only once the
// previous one has handed its result to the output register.
`default_nettype none

`include "assert_macros.svh"

module sector_chain_allocation_map #(
  parameter int MAP_DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire scam_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scam_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [10:0]         cfg_data
);

  import scam_pkg::*;

  localparam int IW = $clog2(MAP_DEPTH);
  localparam int CW = $clog2(MAP_DEPTH + 1);
  localparam logic [IW-1:0] LAST   = IW'(MAP_DEPTH - 1);
  localparam logic [CW-1:0] NS_CNT = CW'(MAP_DEPTH);
  localparam logic [16:0]   NS_W   = 17'(MAP_DEPTH);

  state_t      state_r, state_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          dvalid_r, dvalid_nxt;
  logic [IW-1:0] daddr_r, daddr_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [9:0]    tail_r, tail_nxt;
  logic          tail_ok_r, tail_ok_nxt;
  logic [15:0]   cur_r, cur_nxt;
  logic [10:0]   clen_r, clen_nxt;
  logic [10:0]   k_r, k_nxt;
  logic          res_status_r, res_status_nxt;
  logic [15:0]   res_sector_r, res_sector_nxt;
  logic [10:0]   res_count_r, res_count_nxt;
  logic [10:0]   reserved_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [15:0]   map_rdata;

  logic [15:0]   tail16;
  logic [15:0]   in_tail16;
  logic          in_tail_ok;
  logic [IW-1:0] ptr_inc;
  logic          rd_free;

  assign tail16     = 16'(tail_r);
  assign in_tail16  = 16'(in_item.tail_sector);
  assign in_tail_ok = 17'(in_item.tail_sector) < NS_W;
  assign ptr_inc    = (ptr_r == LAST) ? '0 : ptr_r + IW'(1);
  assign rd_free    = map_rdata == FREE_MARK;

  assign in_ready  = state_r == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  scam_map_ram #(
    .DEPTH (MAP_DEPTH),
    .AW    (IW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (map_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    iss_nxt        = iss_r;
    dvalid_nxt     = dvalid_r;
    daddr_nxt      = daddr_r;
    cmd_nxt        = cmd_r;
    tail_nxt       = tail_r;
    tail_ok_nxt    = tail_ok_r;
    cur_nxt        = cur_r;
    clen_nxt       = clen_r;
    k_nxt          = k_r;
    res_status_nxt = res_status_r;
    res_sector_nxt = res_sector_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = FREE_MARK;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_inc;
        if (ptr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        dvalid_nxt = 1'b0;
        if (in_valid) begin
          cmd_nxt        = in_item.command;
          tail_nxt       = in_item.tail_sector;
          tail_ok_nxt    = in_tail_ok;
          cur_nxt        = 16'(in_item.chain_start);
          clen_nxt       = in_item.chain_length;
          k_nxt          = '0;
          iss_nxt        = '0;
          ptr_nxt        = '0;
          res_status_nxt = STATUS_OK;
          res_sector_nxt = FREE_MARK;
          res_count_nxt  = '0;
          unique case (in_item.command)
            CMD_FORMAT:      state_nxt = ST_FORMAT;
            CMD_ALLOC_FIRST: state_nxt = ST_SCAN;
            CMD_ALLOC_NEXT: begin
              state_nxt = ST_SCAN;
              if (in_tail_ok) begin
                ptr_nxt = in_tail16[IW-1:0];
              end
            end
            CMD_FREE_CHAIN:  state_nxt = ST_WALK_RD;
            CMD_LOOKUP:      state_nxt = in_tail_ok ? ST_LOOKUP_RD : ST_RESP;
            CMD_COUNT_FREE:  state_nxt = ST_SCAN;
            default:         state_nxt = ST_RESP;
          endcase
        end
      end
      ST_FORMAT: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_inc;
        if (17'(ptr_r) < 17'(reserved_r)) begin
          ram_wdata = 16'(ptr_r) + 16'd1;
        end
        if (ptr_r == LAST) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (iss_r != NS_CNT) begin
          ram_re     = 1'b1;
          ptr_nxt    = ptr_inc;
          iss_nxt    = iss_r + CW'(1);
          dvalid_nxt = 1'b1;
          daddr_nxt  = ptr_r;
        end else begin
          dvalid_nxt = 1'b0;
        end
        if (dvalid_r) begin
          if (cmd_r == CMD_COUNT_FREE) begin
            if (rd_free && res_count_r != COUNT_MAX) begin
              res_count_nxt = res_count_r + 11'd1;
            end
            if (iss_r == NS_CNT) begin
              state_nxt = ST_RESP;
            end
          end else if (rd_free) begin
            res_sector_nxt = 16'(daddr_r);
            state_nxt = (cmd_r == CMD_ALLOC_NEXT && tail_ok_r) ? ST_LINK_TAIL : ST_LINK_SELF;
          end else if (iss_r == NS_CNT) begin
            res_status_nxt = STATUS_NO_SPACE;
            state_nxt = (cmd_r == CMD_ALLOC_NEXT) ? ST_WALK_RD : ST_RESP;
          end
        end
      end
      ST_LINK_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = tail16[IW-1:0];
        ram_wdata = res_sector_r;
        state_nxt = ST_LINK_SELF;
      end
      ST_LINK_SELF: begin
        ram_we    = 1'b1;
        ram_waddr = res_sector_r[IW-1:0];
        ram_wdata = res_sector_r;
        state_nxt = ST_RESP;
      end
      ST_WALK_RD: begin
        if (k_r == clen_r || 17'(cur_r) >= NS_W) begin
          state_nxt = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_r[IW-1:0];
          state_nxt = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (rd_free) begin
          state_nxt = ST_RESP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_r[IW-1:0];
          cur_nxt   = map_rdata;
          k_nxt     = k_r + 11'd1;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_LOOKUP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tail16[IW-1:0];
        state_nxt = ST_LOOKUP_WAIT;
      end
      ST_LOOKUP_WAIT: begin
        res_sector_nxt = map_rdata;
        state_nxt      = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt.status     = res_status_r;
          out_item_nxt.sector     = res_sector_r;
          out_item_nxt.free_count = res_count_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      dvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      reserved_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      dvalid_r    <= dvalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        reserved_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    daddr_r      <= daddr_nxt;
    cmd_r        <= cmd_nxt;
    tail_r       <= tail_nxt;
    tail_ok_r    <= tail_ok_nxt;
    cur_r        <= cur_nxt;
    clen_r       <= clen_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_sector_r <= res_sector_nxt;
    res_count_r  <= res_count_nxt;
    out_item_r   <= out_item_nxt;
  end

  // a result word only appears when the sequencer hands one over
  `SCAM_ASSERT_NEXT(a_out_from_resp, !out_valid_r && state_r != ST_RESP, !out_valid_r)
  // an accepted command always moves the sequencer out of idle
  `SCAM_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE)
  // the chain walk only ever frees an entry inside the map
  `SCAM_ASSERT_NOW(a_walk_in_range, state_r == ST_WALK_CHK, 17'(cur_r) < NS_W)

endmodule

`default_nettype wire

// File: test/sector_map_checker.sv
`timescale 1ns / 100ps
// checker that predicts the sector map answers and compares them with the result channel
module sector_map_checker #(
  parameter int MAP_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  scam_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  scam_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [10:0]         cfg_data,
  output int                  fail_count,
  output int                  pending,
  output scam_pkg::out_item_t last_answer
);
  import scam_pkg::*;

  logic [15:0] link_map [MAP_DEPTH];
  logic [10:0] reserved_cnt;
  out_item_t   awaited [$];
  int          mismatches = 0;

  function automatic int find_free(int from);
    for (int i = from; i < MAP_DEPTH; i++)
      if (link_map[i] == FREE_MARK) return i;
    for (int i = 0; i < from; i++)
      if (link_map[i] == FREE_MARK) return i;
    return -1;
  endfunction

  function automatic void release_chain(int first, int count);
    int cur;
    int nxt;
    cur = first;
    for (int k = 0; k < count; k++) begin
      if (cur >= MAP_DEPTH || link_map[cur] == FREE_MARK) return;
      nxt = int'(link_map[cur]);
      link_map[cur] = FREE_MARK;
      cur = nxt;
    end
  endfunction

  function automatic out_item_t map_answer(in_item_t it);
    out_item_t r;
    int        s;
    int        from;
    int        n;
    r.status     = STATUS_OK;
    r.sector     = FREE_MARK;
    r.free_count = '0;
    case (it.command)
      CMD_FORMAT: begin
        for (int i = 0; i < MAP_DEPTH; i++)
          link_map[i] = (i < int'(reserved_cnt)) ? 16'(i + 1) : FREE_MARK;
      end
      CMD_ALLOC_FIRST: begin
        s = find_free(0);
        if (s < 0) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          link_map[s] = 16'(s);
          r.sector    = 16'(s);
        end
      end
      CMD_ALLOC_NEXT: begin
        from = (int'(it.tail_sector) < MAP_DEPTH) ? int'(it.tail_sector) : 0;
        s = find_free(from);
        if (s < 0) begin
          release_chain(int'(it.chain_start), int'(it.chain_length));
          r.status = STATUS_NO_SPACE;
        end else begin
          if (int'(it.tail_sector) < MAP_DEPTH) link_map[it.tail_sector] = 16'(s);
          link_map[s] = 16'(s);
          r.sector    = 16'(s);
        end
      end
      CMD_FREE_CHAIN: release_chain(int'(it.chain_start), int'(it.chain_length));
      CMD_LOOKUP: begin
        if (int'(it.tail_sector) < MAP_DEPTH) r.sector = link_map[it.tail_sector];
      end
      CMD_COUNT_FREE: begin
        n = 0;
        for (int i = 0; i < MAP_DEPTH; i++)
          if (link_map[i] == FREE_MARK && n < int'(COUNT_MAX)) n++;
        r.free_count = 11'(n);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < MAP_DEPTH; i++) link_map[i] = FREE_MARK;
      reserved_cnt = '0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: status %0d sector %h count %0d",
                     out_item.status, out_item.sector, out_item.free_count);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_item.status !== want.status || out_item.sector !== want.sector ||
              out_item.free_count !== want.free_count) begin
            if (mismatches < 10)
              $display("mismatch: expected status %0d sector %h count %0d, got %0d %h %0d",
                       want.status, want.sector, want.free_count,
                       out_item.status, out_item.sector, out_item.free_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) reserved_cnt = cfg_data;
      if (in_valid && in_ready) begin
        fresh = map_answer(in_item);
        awaited.push_back(fresh);
        last_answer <= fresh;
      end
    end
    pending    <= awaited.size();
    fail_count <= mismatches;
  end

endmodule

// File: test/sector_chain_allocation_map_tb.sv
`timescale 1ns / 100ps
// testbench top that drives commands and register writes into the sector chain allocation map
module sector_chain_allocation_map_tb;
  import scam_pkg::*;

  localparam int MAP_DEPTH     = 1024;
  localparam int IDLE_LIMIT    = 20000;
  localparam int DRAIN_CYCLES  = 2 * MAP_DEPTH + 16;
  localparam int SEGMENT_ITEMS = 70;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data  = '0;
  int          fail_count;
  int          pending;
  out_item_t   last_answer;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          sent          = 0;

  sector_chain_allocation_map #(.MAP_DEPTH(MAP_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sector_map_checker #(.MAP_DEPTH(MAP_DEPTH)) map_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .last_answer (last_answer)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= out_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [9:0] tail,
                          input logic [9:0] start, input logic [10:0] len);
    if ($urandom_range(99, 0) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= '{command: cmd, tail_sector: tail, chain_start: start, chain_length: len};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [10:0] value);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one file: first sector, appends, lookups and usually a release
  task automatic grow_chain();
    logic [9:0] head;
    logic [9:0] tail_s;
    int         links;
    int         steps;
    send_cmd(CMD_ALLOC_FIRST, 10'($urandom), 10'($urandom), 11'($urandom));
    wait_results();
    if (last_answer.status == STATUS_NO_SPACE) return;
    head   = last_answer.sector[9:0];
    tail_s = head;
    links  = 1;
    steps  = $urandom_range(6, 0);
    for (int k = 0; k < steps; k++) begin
      send_cmd(CMD_ALLOC_NEXT, tail_s, head, 11'(links + $urandom_range(1, 0)));
      wait_results();
      if (last_answer.status == STATUS_NO_SPACE) return;
      tail_s = last_answer.sector[9:0];
      links++;
    end
    if ($urandom_range(1, 0)) send_cmd(CMD_LOOKUP, head, 10'($urandom), 11'($urandom));
    if ($urandom_range(1, 0)) send_cmd(CMD_LOOKUP, tail_s, 10'($urandom), 11'($urandom));
    case ($urandom_range(3, 0))
      0, 1: send_cmd(CMD_FREE_CHAIN, 10'($urandom), head, 11'(links + $urandom_range(1, 0)));
      2:    send_cmd(CMD_FREE_CHAIN, 10'($urandom), head, 11'($urandom_range(links, 0)));
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [10:0] reserved_plan [8] = '{11'd0, 11'd1024, 11'd2047, 11'd1023,
                                       11'd1, 11'd0, 11'd512, 11'd1024};
    int          in_gap_plan   [4] = '{0, 73, 0, 28};
    int          out_gap_plan  [4] = '{0, 0, 73, 28};
    int          goal;
    int          roll;
    reserved_plan[5] = 11'($urandom_range(1024, 0));
    reserved_plan[6] = 11'($urandom_range(64, 2));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fresh map after reset
    send_cmd(CMD_COUNT_FREE, '0, '0, '0);
    send_cmd(CMD_LOOKUP, '1, '1, '1);
    send_cmd(CMD_ALLOC_FIRST, '0, '0, '0);
    send_cmd(CMD_ALLOC_NEXT, 10'd0, '0, '0);
    send_cmd(CMD_ALLOC_NEXT, '1, '0, '0);
    send_cmd(CMD_LOOKUP, 10'd0, '0, '0);
    send_cmd(CMD_FREE_CHAIN, '0, 10'd0, '1);
    send_cmd(CMD_SPARE_LO, '1, '1, '1);
    send_cmd(CMD_SPARE_HI, '0, '0, '0);

    // completely reserved map
    write_reg(11'd1024);
    send_cmd(CMD_FORMAT, '1, '1, '1);
    send_cmd(CMD_ALLOC_FIRST, '0, '0, '0);
    send_cmd(CMD_ALLOC_NEXT, 10'd5, 10'd0, 11'd3);
    send_cmd(CMD_COUNT_FREE, '0, '0, '0);
    send_cmd(CMD_LOOKUP, 10'd1023, '0, '0);
    send_cmd(CMD_FREE_CHAIN, '0, 10'd3, 11'd1024);
    send_cmd(CMD_FREE_CHAIN, '0, 10'd3, 11'd0);

    // reserved count beyond the map size
    write_reg(11'd2047);
    send_cmd(CMD_FORMAT, '0, '0, '0);
    send_cmd(CMD_COUNT_FREE, '0, '0, '0);

    // one free sector, then a wrapping append
    write_reg(11'd1023);
    send_cmd(CMD_FORMAT, '0, '0, '0);
    send_cmd(CMD_ALLOC_FIRST, '0, '0, '0);
    send_cmd(CMD_ALLOC_FIRST, '0, '0, '0);
    send_cmd(CMD_FREE_CHAIN, '0, 10'd0, 11'd5);
    send_cmd(CMD_ALLOC_NEXT, 10'd1023, '0, '0);
    send_cmd(CMD_LOOKUP, 10'd1023, '0, '0);

    for (int seg = 0; seg < 8; seg++) begin
      write_reg(reserved_plan[seg]);
      in_idle_pct   = in_gap_plan[seg / 2];
      out_stall_pct <= out_gap_plan[seg / 2];
      goal = sent + SEGMENT_ITEMS;
      send_cmd(CMD_FORMAT, 10'($urandom), 10'($urandom), 11'($urandom));
      while (sent < goal) begin
        roll = $urandom_range(99, 0);
        if (roll < 15)
          send_cmd(3'($urandom_range(7, 0)), 10'($urandom), 10'($urandom),
                   11'($urandom_range(2047, 0)));
        else if (roll < 20)
          send_cmd(CMD_FORMAT, 10'($urandom), 10'($urandom), 11'($urandom));
        else if (roll < 25)
          send_cmd(CMD_COUNT_FREE, 10'($urandom), 10'($urandom), 11'($urandom));
        else if (roll < 30)
          send_cmd(CMD_LOOKUP, 10'($urandom), 10'($urandom), 11'($urandom));
        else
          grow_chain();
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
